FILE: sv/dcqp_pkg.sv
// Shared constants, codes and control/status types of the display command queue pacer.
// No dependencies; the top level, datapath, controller and testbench import this package.
package dcqp_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = 4;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int ENTRY_W     = 26;
   localparam int SER_MAX     = 5;

   localparam logic [15:0] TICK_MAX  = 16'hFFFF;
   localparam logic [7:0]  TALLY_MAX = 8'hFF;
   localparam logic [7:0]  BYTE_MAX  = 8'hFF;

   localparam logic [1:0] OP_ENQUEUE = 2'd0;
   localparam logic [1:0] OP_TICK    = 2'd1;
   localparam logic [1:0] OP_XFER    = 2'd2;

   localparam logic [1:0] CT_CHAR    = 2'd0;
   localparam logic [1:0] CT_SPECIAL = 2'd1;
   localparam logic [1:0] CT_SETTING = 2'd2;
   localparam logic [1:0] CT_RGB     = 2'd3;

   localparam logic [1:0] MODE_READY = 2'd0;
   localparam logic [1:0] MODE_AWAIT = 2'd1;
   localparam logic [1:0] MODE_PACE  = 2'd2;
   localparam logic [1:0] MODE_ERROR = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_PACE     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RECOVERY = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPECIAL  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTING  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RGB      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAR    = 3'd6;

   localparam logic [15:0] PACE_RESET     = 16'd50;
   localparam logic [15:0] RECOVERY_RESET = 16'd1000;
   localparam logic [7:0]  LIMIT_RESET    = 8'd1;
   localparam logic [7:0]  SPECIAL_RESET  = 8'd254;
   localparam logic [7:0]  SETTING_RESET  = 8'd124;
   localparam logic [7:0]  RGB_RESET      = 8'd43;
   localparam logic [7:0]  CLEAR_RESET    = 8'd45;

   typedef struct packed {
      logic capture;
      logic exec;
      logic reinit_push;
      logic load_single;
      logic load_byte;
   } dcqp_ctl_type;

   typedef struct packed {
      logic do_reinit;
      logic do_send;
      logic byte_last;
      logic rsp_free;
   } dcqp_sts_type;

endpackage

FILE: sv/dcqp_req_if.sv
// Request channel of the display command queue pacer: valid/ready plus one input item.
// No dependencies.
interface dcqp_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [1:0] cmd_type;
   logic [7:0] byte0;
   logic [7:0] byte1;
   logic [7:0] byte2;
   logic       ack_ok;

   modport source (output valid, cmd, cmd_type, byte0, byte1, byte2, ack_ok, input ready);
   modport sink   (input valid, cmd, cmd_type, byte0, byte1, byte2, ack_ok, output ready);
endinterface

FILE: sv/dcqp_rsp_if.sv
// Response channel of the display command queue pacer: valid/ready plus one result item.
// No dependencies.
interface dcqp_rsp_if;
   logic       valid;
   logic       ready;
   logic       is_byte;
   logic [7:0] out_byte;
   logic       last;
   logic       accepted;
   logic [1:0] status;
   logic [3:0] queue_count;
   logic [7:0] error_count;

   modport source (output valid, is_byte, out_byte, last, accepted, status, queue_count,
                   error_count, input ready);
   modport sink   (input valid, is_byte, out_byte, last, accepted, status, queue_count,
                   error_count, output ready);
endinterface

FILE: sv/display_command_queue_pacer.sv
// Display command queue pacer top level: controller plus datapath, request/response channels.
// Each request is captured, executed, then answered through the registered response output.
// Only one item is in flight; its n results (1..5) leave the output register at one byte per
// cycle while the response channel is ready. A reinit adds a push step: the command memory has a single write port.
// Reset: synchronous; clears queue pointers, mode, tick and error counters, loads register
// defaults; command memory contents are left as they are.
module display_command_queue_pacer (
   input  logic                            clock,
   input  logic                            reset,
   dcqp_req_if.sink                        req_chan,
   dcqp_rsp_if.source                      rsp_chan,
   input  logic                            csr_we,
   input  logic [dcqp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [dcqp_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import dcqp_pkg::*;

   dcqp_ctl_type ctl;
   dcqp_sts_type sts;
   logic         req_ready;

   assign req_chan.ready = req_ready;

   dcqp_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   dcqp_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .sts             (sts),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .in_cmd          (req_chan.cmd),
      .in_cmd_type     (req_chan.cmd_type),
      .in_byte0        (req_chan.byte0),
      .in_byte1        (req_chan.byte1),
      .in_byte2        (req_chan.byte2),
      .in_ack_ok       (req_chan.ack_ok),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_is_byte     (rsp_chan.is_byte),
      .rsp_out_byte    (rsp_chan.out_byte),
      .rsp_last        (rsp_chan.last),
      .rsp_accepted    (rsp_chan.accepted),
      .rsp_status      (rsp_chan.status),
      .rsp_queue_count (rsp_chan.queue_count),
      .rsp_error_count (rsp_chan.error_count)
   );

`ifndef SYNTHESIS
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request taken while an item is in progress");

   a_exec_after_transfer: assert property (@(posedge clock) disable iff (reset)
      ctl.exec |-> $past(req_chan.valid && req_chan.ready))
      else $error("execution without a request transfer");

   a_bytes_await: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.is_byte) |-> (rsp_chan.status == MODE_AWAIT))
      else $error("link byte reported outside awaiting ack");
`endif

endmodule

FILE: sv/dcqp_datapath.sv
// Datapath: config registers, command ring memory, mode/tick/error state, serializer
// and response output register. Depends on dcqp_pkg.
module dcqp_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  dcqp_pkg::dcqp_ctl_type             ctl,
   output dcqp_pkg::dcqp_sts_type             sts,
   input  logic                               csr_we,
   input  logic [dcqp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dcqp_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic [1:0]                         in_cmd,
   input  logic [1:0]                         in_cmd_type,
   input  logic [7:0]                         in_byte0,
   input  logic [7:0]                         in_byte1,
   input  logic [7:0]                         in_byte2,
   input  logic                               in_ack_ok,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic                               rsp_is_byte,
   output logic [7:0]                         rsp_out_byte,
   output logic                               rsp_last,
   output logic                               rsp_accepted,
   output logic [1:0]                         rsp_status,
   output logic [3:0]                         rsp_queue_count,
   output logic [7:0]                         rsp_error_count
);
   import dcqp_pkg::*;

   logic [15:0] pace_ff, recov_ff;
   logic [7:0]  limit_ff, sp_ff, setp_ff, rgb_ff, clear_ff;

   logic [1:0]  op_ff, type_ff;
   logic [7:0]  b0_ff, b1_ff, b2_ff;
   logic        ack_ff;

   logic [PTR_W-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [1:0]       mode_ff, mode_in;
   logic [15:0]      elapsed_ff, elapsed_in;
   logic [7:0]       tally_ff, tally_in;
   logic             acc_ff, acc_in;

   logic [ENTRY_W-1:0] mem [QUEUE_DEPTH];
   logic [ENTRY_W-1:0] rd_ff;
   logic               wr_en;
   logic [PTR_W-1:0]   wr_addr;
   logic [ENTRY_W-1:0] wr_data;

   logic [7:0] bytes_ff [SER_MAX];
   logic [2:0] left_ff;
   logic [7:0] ser_bytes [SER_MAX];
   logic [2:0] ser_last;

   logic             rsp_valid_ff, rsp_is_byte_ff, rsp_last_ff, rsp_acc_ff;
   logic [7:0]       rsp_byte_ff, rsp_err_ff;
   logic [1:0]       rsp_status_ff;
   logic [CNT_W-1:0] rsp_count_ff;

   logic [PTR_W-1:0] tail_nxt, head_nxt;
   logic             full, empty, err_trip, reinit_now, send_now;
   logic [7:0]       tally_inc;
   logic [15:0]      el_inc;
   logic [PTR_W:0]   count;
   logic [1:0]       rd_type;
   logic [7:0]       rd_b0;

   assign tail_nxt  = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
   assign head_nxt  = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign full      = (tail_nxt == head_ff);
   assign empty     = (tail_ff == head_ff);
   assign tally_inc = (tally_ff == TALLY_MAX) ? tally_ff : tally_ff + 8'd1;
   assign err_trip  = (tally_inc > limit_ff);
   assign el_inc    = (elapsed_ff == TICK_MAX) ? elapsed_ff : elapsed_ff + 16'd1;
   assign reinit_now = (op_ff == OP_TICK) && (mode_ff == MODE_ERROR) && (el_inc >= recov_ff);
   assign send_now   = (op_ff == OP_TICK) && (mode_ff == MODE_READY) && !empty;
   assign count = (tail_ff >= head_ff) ? ({1'b0, tail_ff} - {1'b0, head_ff})
                : ({1'b0, tail_ff} + (PTR_W + 1)'(QUEUE_DEPTH) - {1'b0, head_ff});
   assign rd_type = rd_ff[25:24];
   assign rd_b0   = rd_ff[7:0];

   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      mode_in    = mode_ff;
      elapsed_in = elapsed_ff;
      tally_in   = tally_ff;
      acc_in     = acc_ff;
      wr_en      = 1'b0;
      wr_addr    = tail_ff;
      wr_data    = {type_ff, b2_ff, b1_ff, b0_ff};
      if (ctl.exec) begin
         acc_in = 1'b0;
         case (op_ff)
            OP_ENQUEUE: begin
               if (full) begin
                  tally_in   = tally_inc;
                  elapsed_in = '0;
                  if (err_trip) begin
                     mode_in = MODE_ERROR;
                     head_in = '0;
                     tail_in = '0;
                  end
               end else begin
                  wr_en   = 1'b1;
                  tail_in = tail_nxt;
                  acc_in  = 1'b1;
               end
            end
            OP_TICK: begin
               elapsed_in = el_inc;
               case (mode_ff)
                  MODE_PACE: begin
                     if (el_inc >= pace_ff) mode_in = MODE_READY;
                  end
                  MODE_ERROR: begin
                     if (reinit_now) begin
                        head_in    = '0;
                        tally_in   = '0;
                        elapsed_in = '0;
                        mode_in    = MODE_PACE;
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_data    = {CT_SPECIAL, 8'd0, 8'd0, clear_ff};
                        tail_in    = PTR_W'(1);
                     end
                  end
                  MODE_READY: begin
                     if (!empty) mode_in = MODE_AWAIT;
                  end
                  default: ;
               endcase
            end
            OP_XFER: begin
               if (mode_ff == MODE_AWAIT) begin
                  if (ack_ff) begin
                     head_in    = head_nxt;
                     mode_in    = MODE_PACE;
                     elapsed_in = '0;
                  end else begin
                     tally_in   = tally_inc;
                     elapsed_in = '0;
                     mode_in    = MODE_READY;
                     if (err_trip) begin
                        mode_in = MODE_ERROR;
                        head_in = '0;
                        tail_in = '0;
                     end
                  end
               end
            end
            default: ;
         endcase
      end else if (ctl.reinit_push) begin
         wr_en   = 1'b1;
         wr_addr = PTR_W'(1);
         wr_data = {CT_RGB, BYTE_MAX, BYTE_MAX, BYTE_MAX};
         tail_in = PTR_W'(2);
      end
   end

   always_comb begin
      for (int i = 0; i < SER_MAX; i++) ser_bytes[i] = rd_b0;
      ser_last = 3'd0;
      case (rd_type)
         CT_CHAR: begin
            if ((rd_b0 == sp_ff) || (rd_b0 == setp_ff)) ser_last = 3'd1;
         end
         CT_SPECIAL: begin
            ser_bytes[0] = sp_ff;
            ser_last     = 3'd1;
         end
         CT_SETTING: begin
            ser_bytes[0] = setp_ff;
            ser_last     = 3'd1;
         end
         default: begin
            ser_bytes[0] = setp_ff;
            ser_bytes[1] = rgb_ff;
            ser_bytes[2] = rd_b0;
            ser_bytes[3] = rd_ff[15:8];
            ser_bytes[4] = rd_ff[23:16];
            ser_last     = 3'd4;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pace_ff  <= PACE_RESET;
         recov_ff <= RECOVERY_RESET;
         limit_ff <= LIMIT_RESET;
         sp_ff    <= SPECIAL_RESET;
         setp_ff  <= SETTING_RESET;
         rgb_ff   <= RGB_RESET;
         clear_ff <= CLEAR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PACE:     pace_ff  <= csr_wdata;
            CSR_RECOVERY: recov_ff <= csr_wdata;
            CSR_LIMIT:    limit_ff <= csr_wdata[7:0];
            CSR_SPECIAL:  sp_ff    <= csr_wdata[7:0];
            CSR_SETTING:  setp_ff  <= csr_wdata[7:0];
            CSR_RGB:      rgb_ff   <= csr_wdata[7:0];
            CSR_CLEAR:    clear_ff <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         op_ff   <= in_cmd;
         type_ff <= in_cmd_type;
         b0_ff   <= in_byte0;
         b1_ff   <= in_byte1;
         b2_ff   <= in_byte2;
         ack_ff  <= in_ack_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         tail_ff    <= '0;
         mode_ff    <= MODE_READY;
         elapsed_ff <= '0;
         tally_ff   <= '0;
      end else begin
         head_ff    <= head_in;
         tail_ff    <= tail_in;
         mode_ff    <= mode_in;
         elapsed_ff <= elapsed_in;
         tally_ff   <= tally_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[head_ff];
   end

   // load the serialized bytes, then shift one out per transfer
   always_ff @(posedge clock) begin
      if (ctl.exec && send_now) begin
         for (int i = 0; i < SER_MAX; i++) bytes_ff[i] <= ser_bytes[i];
         left_ff <= ser_last;
      end else if (ctl.load_byte) begin
         for (int i = 0; i < SER_MAX - 1; i++) bytes_ff[i] <= bytes_ff[i+1];
         left_ff <= left_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.load_single || ctl.load_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_single || ctl.load_byte) begin
         rsp_is_byte_ff <= ctl.load_byte;
         rsp_byte_ff    <= ctl.load_byte ? bytes_ff[0] : 8'd0;
         rsp_last_ff    <= ctl.load_single || (left_ff == 3'd0);
         rsp_acc_ff     <= ctl.load_single && acc_ff;
         rsp_status_ff  <= mode_ff;
         rsp_count_ff   <= CNT_W'(count);
         rsp_err_ff     <= tally_ff;
      end
   end

   assign sts.do_reinit = reinit_now;
   assign sts.do_send   = send_now;
   assign sts.byte_last = (left_ff == 3'd0);
   assign sts.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_is_byte     = rsp_is_byte_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_accepted    = rsp_acc_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_queue_count = rsp_count_ff;
   assign rsp_error_count = rsp_err_ff;

endmodule

FILE: sv/dcqp_controller.sv
// Controller: sequences capture, execution, reinit push and result transfers.
// Depends on dcqp_pkg.
module dcqp_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  dcqp_pkg::dcqp_sts_type sts,
   output dcqp_pkg::dcqp_ctl_type ctl
);
   import dcqp_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_REINIT,
      S_SINGLE,
      S_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (sts.do_reinit)    state_in = S_REINIT;
            else if (sts.do_send) state_in = S_EMIT;
            else                  state_in = S_SINGLE;
         end
         S_REINIT: state_in = S_SINGLE;
         S_SINGLE: begin
            if (sts.rsp_free) state_in = S_IDLE;
         end
         S_EMIT: begin
            if (sts.rsp_free && sts.byte_last) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready       = (state_ff == S_IDLE) && !reset;
   assign ctl.capture     = req_ready && req_valid;
   assign ctl.exec        = (state_ff == S_EXEC);
   assign ctl.reinit_push = (state_ff == S_REINIT);
   assign ctl.load_single = (state_ff == S_SINGLE) && sts.rsp_free;
   assign ctl.load_byte   = (state_ff == S_EMIT) && sts.rsp_free;

endmodule

FILE: tb/sv/tb_display_command_queue_pacer.sv
`timescale 1ns / 1ps
// Self-checking testbench for display_command_queue_pacer: directed and random command traffic
// against an in-bench queue/serializer model, with random stalls on both channels.
// Depends on dcqp_pkg, dcqp_req_if, dcqp_rsp_if and the pacer RTL.
module tb_display_command_queue_pacer;
   import dcqp_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0] cmd;
      logic [1:0] cmd_type;
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic       ack_ok;
   } pacer_req_t;

   typedef struct packed {
      logic       is_byte;
      logic [7:0] out_byte;
      logic       last;
      logic       accepted;
      logic [1:0] status;
      logic [3:0] queue_count;
      logic [7:0] error_count;
   } link_result_t;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dcqp_req_if req_chan ();
   dcqp_rsp_if rsp_chan ();

   display_command_queue_pacer uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // pacer model state
   logic [ENTRY_W-1:0] cmd_mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]   q_head;
   logic [PTR_W-1:0]   q_tail;
   logic [1:0]         pacer_mode;
   logic [15:0]        tick_elapsed;
   logic [7:0]         err_tally_m;

   logic [15:0] cfg_pace;
   logic [15:0] cfg_recovery;
   logic [7:0]  cfg_limit;
   logic [7:0]  cfg_special;
   logic [7:0]  cfg_setting;
   logic [7:0]  cfg_rgb;
   logic [7:0]  cfg_clear;

   link_result_t pending_link_results [$];
   link_result_t want;

   bit idle_enable;
   int rsp_stall_left;
   int fail_count;
   int requests_sent;
   int results_checked;
   int link_bytes_predicted;
   int overflow_count;
   int reinit_count;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #(2_000_000);
      $display("== FAIL ==");
      $finish;
   end

   task automatic note_failure(string msg);
      fail_count++;
      $display("%0t ns mismatch: %s", $time, msg);
   endtask

   task automatic check_field(string name, logic [7:0] got, logic [7:0] exp_val);
      if (got !== exp_val)
         note_failure($sformatf("%s got %0h expected %0h", name, got, exp_val));
   endtask

   function automatic logic [CNT_W-1:0] queued_count();
      return q_tail - q_head;
   endfunction

   function automatic void log_result(bit isb, logic [7:0] b, bit lst, bit acc);
      link_result_t r;
      r.is_byte     = isb;
      r.out_byte    = b;
      r.last        = lst;
      r.accepted    = acc;
      r.status      = pacer_mode;
      r.queue_count = queued_count();
      r.error_count = err_tally_m;
      pending_link_results.push_back(r);
   endfunction

   function automatic void note_error();
      if (err_tally_m != TALLY_MAX) err_tally_m++;
      tick_elapsed = '0;
      if (err_tally_m > cfg_limit) begin
         pacer_mode = MODE_ERROR;
         q_head     = '0;
         q_tail     = '0;
      end
   endfunction

   function automatic bit store_command(logic [1:0] ct, logic [7:0] b0, logic [7:0] b1,
                                        logic [7:0] b2);
      logic [PTR_W-1:0] nxt;
      nxt = q_tail + 1'b1;
      if (nxt == q_head) begin
         overflow_count++;
         note_error();
         return 1'b0;
      end
      cmd_mem[q_tail] = {ct, b2, b1, b0};
      q_tail = nxt;
      return 1'b1;
   endfunction

   function automatic void reset_pacer_model();
      q_head       = '0;
      q_tail       = '0;
      pacer_mode   = MODE_READY;
      tick_elapsed = '0;
      err_tally_m  = '0;
      cfg_pace     = PACE_RESET;
      cfg_recovery = RECOVERY_RESET;
      cfg_limit    = LIMIT_RESET;
      cfg_special  = SPECIAL_RESET;
      cfg_setting  = SETTING_RESET;
      cfg_rgb      = RGB_RESET;
      cfg_clear    = CLEAR_RESET;
   endfunction

   function automatic void predict_link_step(pacer_req_t it);
      logic [7:0]         ser [SER_MAX];
      logic [ENTRY_W-1:0] e;
      int                 n;
      bit                 ok;
      n = 0;
      case (it.cmd)
         OP_ENQUEUE: begin
            ok = store_command(it.cmd_type, it.byte0, it.byte1, it.byte2);
            log_result(1'b0, 8'h00, 1'b1, ok);
            return;
         end
         OP_TICK: begin
            if (tick_elapsed != TICK_MAX) tick_elapsed++;
            case (pacer_mode)
               MODE_PACE: begin
                  if (tick_elapsed >= cfg_pace) pacer_mode = MODE_READY;
               end
               MODE_ERROR: begin
                  if (tick_elapsed >= cfg_recovery) begin
                     q_head       = '0;
                     q_tail       = '0;
                     err_tally_m  = '0;
                     tick_elapsed = '0;
                     pacer_mode   = MODE_PACE;
                     reinit_count++;
                     void'(store_command(CT_SPECIAL, cfg_clear, 8'h00, 8'h00));
                     void'(store_command(CT_RGB, BYTE_MAX, BYTE_MAX, BYTE_MAX));
                  end
               end
               MODE_READY: begin
                  if (q_head != q_tail) begin
                     e = cmd_mem[q_head];
                     case (e[25:24])
                        CT_CHAR: begin
                           if (e[7:0] == cfg_special || e[7:0] == cfg_setting) begin
                              ser[n] = e[7:0];
                              n++;
                           end
                           ser[n] = e[7:0];
                           n++;
                        end
                        CT_SPECIAL: begin
                           ser[0] = cfg_special;
                           ser[1] = e[7:0];
                           n = 2;
                        end
                        CT_SETTING: begin
                           ser[0] = cfg_setting;
                           ser[1] = e[7:0];
                           n = 2;
                        end
                        default: begin
                           ser[0] = cfg_setting;
                           ser[1] = cfg_rgb;
                           ser[2] = e[7:0];
                           ser[3] = e[15:8];
                           ser[4] = e[23:16];
                           n = 5;
                        end
                     endcase
                     pacer_mode = MODE_AWAIT;
                  end
               end
               default: ;
            endcase
         end
         OP_XFER: begin
            if (pacer_mode == MODE_AWAIT) begin
               if (it.ack_ok) begin
                  q_head       = q_head + 1'b1;
                  pacer_mode   = MODE_PACE;
                  tick_elapsed = '0;
               end else begin
                  pacer_mode = MODE_READY;
                  note_error();
               end
            end
         end
         default: ;
      endcase
      if (n == 0) begin
         log_result(1'b0, 8'h00, 1'b1, 1'b0);
      end else begin
         for (int k = 0; k < n; k++) log_result(1'b1, ser[k], k == n - 1, 1'b0);
         link_bytes_predicted += n;
      end
   endfunction

   function automatic pacer_req_t make_item(logic [1:0] op, logic [1:0] ct, logic [7:0] b0,
                                            logic [7:0] b1, logic [7:0] b2, bit ack);
      pacer_req_t it;
      it.cmd      = op;
      it.cmd_type = ct;
      it.byte0    = b0;
      it.byte1    = b1;
      it.byte2    = b2;
      it.ack_ok   = ack;
      return it;
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic pacer_req_t tick_item();
      return make_item(OP_TICK, 2'($urandom_range(0, 3)), rand_byte(), rand_byte(),
                       rand_byte(), 1'($urandom_range(0, 1)));
   endfunction

   function automatic pacer_req_t xfer_item(bit ok);
      return make_item(OP_XFER, 2'($urandom_range(0, 3)), rand_byte(), rand_byte(),
                       rand_byte(), ok);
   endfunction

   function automatic pacer_req_t enq_item(logic [1:0] ct, logic [7:0] b0, logic [7:0] b1,
                                           logic [7:0] b2);
      return make_item(OP_ENQUEUE, ct, b0, b1, b2, 1'($urandom_range(0, 1)));
   endfunction

   // bias characters toward the prefix codes so escaping is hit often
   function automatic pacer_req_t random_enqueue();
      logic [7:0] b0;
      case ($urandom_range(0, 3))
         0:       b0 = cfg_special;
         1:       b0 = cfg_setting;
         default: b0 = rand_byte();
      endcase
      return enq_item(2'($urandom_range(0, 3)), b0, rand_byte(), rand_byte());
   endfunction

   function automatic logic [7:0] rand_code();
      case ($urandom_range(0, 3))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return rand_byte();
      endcase
   endfunction

   task automatic send_request(pacer_req_t it);
      int gap;
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.cmd      <= it.cmd;
      req_chan.cmd_type <= it.cmd_type;
      req_chan.byte0    <= it.byte0;
      req_chan.byte1    <= it.byte1;
      req_chan.byte2    <= it.byte2;
      req_chan.ack_ok   <= it.ack_ok;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) @(posedge clock);
      predict_link_step(it);
      requests_sent++;
   endtask

   task automatic wait_link_idle();
      req_chan.valid <= 1'b0;
      while (pending_link_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   task automatic program_registers(logic [15:0] pace, logic [15:0] recovery, logic [7:0] limit,
                                    logic [7:0] sp, logic [7:0] setp, logic [7:0] rgb,
                                    logic [7:0] clr);
      wait_link_idle();
      write_csr(CSR_PACE, pace);
      write_csr(CSR_RECOVERY, recovery);
      write_csr(CSR_LIMIT, {8'h00, limit});
      write_csr(CSR_SPECIAL, {8'h00, sp});
      write_csr(CSR_SETTING, {8'h00, setp});
      write_csr(CSR_RGB, {8'h00, rgb});
      write_csr(CSR_CLEAR, {8'h00, clr});
      csr_we       <= 1'b0;
      cfg_pace     = pace;
      cfg_recovery = recovery;
      cfg_limit    = limit;
      cfg_special  = sp;
      cfg_setting  = setp;
      cfg_rgb      = rgb;
      cfg_clear    = clr;
   endtask

   task automatic program_random_registers();
      program_registers(16'($urandom_range(0, 4)), 16'($urandom_range(0, 6)),
                        8'($urandom_range(0, 4)), rand_code(), rand_code(), rand_code(),
                        rand_code());
   endtask

   // steer by model mode so most traffic forms complete send/ack/pace cycles
   task automatic run_traffic(int n_items);
      pacer_req_t it;
      int         done;
      int         r;
      done = 0;
      while (done < n_items) begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            it = make_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), rand_byte(),
                           rand_byte(), rand_byte(), 1'($urandom_range(0, 1)));
         end else begin
            case (pacer_mode)
               MODE_READY: begin
                  if (q_head == q_tail || r < 35) it = random_enqueue();
                  else it = tick_item();
               end
               MODE_AWAIT: begin
                  if (r < 85) it = xfer_item($urandom_range(0, 3) != 0);
                  else if (r < 92) it = tick_item();
                  else it = random_enqueue();
               end
               default: begin
                  if (r < 80) it = tick_item();
                  else it = random_enqueue();
               end
            endcase
         end
         if (!(it.cmd == OP_UNUSED || (it.cmd == OP_XFER && pacer_mode != MODE_AWAIT))) done++;
         send_request(it);
      end
   endtask

   task automatic test_directed_commands();
      send_request(enq_item(CT_CHAR, SPECIAL_RESET, 8'h00, 8'h00));
      send_request(tick_item());
      send_request(xfer_item(1'b1));
      send_request(xfer_item(1'b1));
      send_request(make_item(OP_UNUSED, CT_RGB, 8'hFF, 8'hFF, 8'hFF, 1'b1));
      program_registers(16'd0, 16'd2, 8'd3, SPECIAL_RESET, SETTING_RESET, RGB_RESET,
                        CLEAR_RESET);
      send_request(tick_item());
      send_request(enq_item(CT_CHAR, 8'h41, 8'h00, 8'h00));
      send_request(enq_item(CT_CHAR, SETTING_RESET, 8'hFF, 8'hFF));
      send_request(enq_item(CT_SPECIAL, 8'h00, 8'h00, 8'h00));
      send_request(enq_item(CT_SETTING, 8'hFF, 8'h00, 8'h00));
      send_request(enq_item(CT_RGB, 8'h00, 8'hFF, 8'h55));
      send_request(tick_item());
      send_request(xfer_item(1'b0));
      for (int i = 0; i < 5; i++) begin
         send_request(tick_item());
         send_request(xfer_item(1'b1));
         send_request(tick_item());
      end
   endtask

   task automatic test_error_recovery();
      program_registers(16'd1, 16'd2, 8'd0, SPECIAL_RESET, SETTING_RESET, RGB_RESET,
                        CLEAR_RESET);
      send_request(random_enqueue());
      while (pacer_mode != MODE_AWAIT) send_request(tick_item());
      send_request(xfer_item(1'b0));
      while (pacer_mode == MODE_ERROR) send_request(tick_item());
      run_traffic(20);
   endtask

   task automatic test_queue_overflow();
      program_registers(16'd0, 16'd1, 8'd20, rand_code(), rand_code(), rand_code(),
                        rand_code());
      while (pacer_mode != MODE_ERROR) send_request(random_enqueue());
      repeat (17) send_request(random_enqueue());
      run_traffic(10);
   endtask

   task automatic test_random_traffic();
      program_registers(16'd1, 16'd3, 8'd2, rand_byte(), rand_byte(), rand_byte(), rand_byte());
      run_traffic(15);
      program_registers(16'd0, 16'd0, 8'd0, 8'h00, 8'hFF, 8'h00, 8'hFF);
      run_traffic(15);
      program_registers(16'hFFFF, 16'hFFFF, 8'd254, 8'hFF, 8'h00, 8'hFF, 8'h00);
      run_traffic(10);
      program_random_registers();
      run_traffic(15);
      program_random_registers();
      run_traffic(15);
   endtask

   task automatic test_steady_stream();
      idle_enable = 1'b0;
      program_random_registers();
      run_traffic(30);
   endtask

   always @(posedge clock) begin
      if (rsp_stall_left != 0) begin
         rsp_stall_left <= rsp_stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 4) == 0) begin
         rsp_stall_left <= $urandom_range(0, 4);
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_link_results.size() == 0) begin
            note_failure("result transfer with nothing expected");
         end else begin
            want = pending_link_results.pop_front();
            check_field("is_byte", 8'(rsp_chan.is_byte), 8'(want.is_byte));
            check_field("out_byte", rsp_chan.out_byte, want.out_byte);
            check_field("last", 8'(rsp_chan.last), 8'(want.last));
            check_field("accepted", 8'(rsp_chan.accepted), 8'(want.accepted));
            check_field("status", 8'(rsp_chan.status), 8'(want.status));
            check_field("queue_count", 8'(rsp_chan.queue_count), 8'(want.queue_count));
            check_field("error_count", rsp_chan.error_count, want.error_count);
            results_checked++;
         end
      end
   end

   initial begin
      int drain_cycles;
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= '0;
      csr_wdata         <= '0;
      req_chan.valid    <= 1'b0;
      req_chan.cmd      <= OP_ENQUEUE;
      req_chan.cmd_type <= CT_CHAR;
      req_chan.byte0    <= 8'h00;
      req_chan.byte1    <= 8'h00;
      req_chan.byte2    <= 8'h00;
      req_chan.ack_ok   <= 1'b0;
      idle_enable       = 1'b1;
      reset_pacer_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed_commands();
      test_error_recovery();
      test_queue_overflow();
      test_random_traffic();
      test_steady_stream();

      req_chan.valid <= 1'b0;
      drain_cycles = 0;
      while (pending_link_results.size() != 0 && drain_cycles < 5000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (10) @(posedge clock);
      if (pending_link_results.size() != 0)
         note_failure($sformatf("%0d expected results never arrived",
                                pending_link_results.size()));

      $display("run: %0d requests, %0d results checked, %0d serialized link bytes",
               requests_sent, results_checked, link_bytes_predicted);
      $display("run: %0d queue overflows, %0d error recoveries, %0d mismatches",
               overflow_count, reinit_count, fail_count);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
